FILE: hw/rtl/ccenc_pkg.sv
// ============================================================================
// ccenc_pkg
// Shared constants, register indexes and types of the configurable
// convolutional encoder.
// ============================================================================
package ccenc_pkg;

    // Code geometry: code bits per word, data bits per word, memory per group.
    localparam int N_OUT   = 2;
    localparam int K_IN    = 1;
    localparam int MEM     = 6;

    // Derived widths.
    localparam int GRP_LEN = MEM + 1;
    localparam int OTAP_W  = N_OUT * K_IN * GRP_LEN;
    localparam int FTAP_W  = K_IN * K_IN * GRP_LEN;
    localparam int STATE_W = K_IN * MEM;
    localparam int CFG_W   = (OTAP_W > FTAP_W) ? OTAP_W : FTAP_W;
    localparam int CFG_IDX_W = 2;

    // Reset value of the output tap register (octal 133, 171).
    localparam logic [OTAP_W-1:0] OTAP_RESET = OTAP_W'(11769);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_TAPS     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_TAPS   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_ENABLE = CFG_IDX_W'(2);

    // Current configuration as seen by the encoding logic.
    typedef struct packed {
        logic [OTAP_W-1:0] output_taps;
        logic [FTAP_W-1:0] feedback_taps;
        logic              feedback_enable;
    } t_cfg;

endpackage

FILE: hw/rtl/ccenc_cfg.sv
// ============================================================================
// ccenc_cfg
// Configuration register file: decodes the write port into the output tap,
// feedback tap and feedback enable registers.
// ============================================================================
module ccenc_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ccenc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ccenc_pkg::CFG_W-1:0]     i_cfg_data,
    output ccenc_pkg::t_cfg                 o_cfg
);

    logic [ccenc_pkg::OTAP_W-1:0] r_output_taps;
    logic [ccenc_pkg::FTAP_W-1:0] r_feedback_taps;
    logic                         r_feedback_enable;

    // Register writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_taps     <= ccenc_pkg::OTAP_RESET;
            r_feedback_taps   <= '0;
            r_feedback_enable <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ccenc_pkg::CFG_OUTPUT_TAPS: begin
                    r_output_taps <= i_cfg_data[ccenc_pkg::OTAP_W-1:0];
                end
                ccenc_pkg::CFG_FEEDBACK_TAPS: begin
                    r_feedback_taps <= i_cfg_data[ccenc_pkg::FTAP_W-1:0];
                end
                ccenc_pkg::CFG_FEEDBACK_ENABLE: begin
                    r_feedback_enable <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.output_taps     = r_output_taps;
    assign o_cfg.feedback_taps   = r_feedback_taps;
    assign o_cfg.feedback_enable = r_feedback_enable;

endmodule

FILE: hw/rtl/ccenc_core.sv
// ============================================================================
// ccenc_core
// Encoding logic for one word: builds the tap vectors, applies the optional
// recursive feedback, forms the code bits and the next shift state.
// ============================================================================
module ccenc_core (
    input  logic [ccenc_pkg::K_IN-1:0]    i_data_bits,
    input  logic [ccenc_pkg::STATE_W-1:0] i_state,
    input  ccenc_pkg::t_cfg               i_cfg,
    output logic [ccenc_pkg::N_OUT-1:0]   o_code_word,
    output logic [ccenc_pkg::STATE_W-1:0] o_next_state
);

    localparam int K   = ccenc_pkg::K_IN;
    localparam int M   = ccenc_pkg::MEM;
    localparam int G   = ccenc_pkg::GRP_LEN;
    localparam int OW  = ccenc_pkg::OTAP_W;
    localparam int FW  = ccenc_pkg::FTAP_W;

    // One tap vector per input group; position 0 is the new bit.
    logic [K-1:0][G-1:0] vec;
    logic                fb_acc;
    logic                out_acc;

    always_comb begin
        fb_acc       = 1'b0;
        out_acc      = 1'b0;
        o_code_word  = '0;
        o_next_state = '0;

        // Gather the new bit and the stored bits of each group, newest first.
        for (int j = 0; j < K; j++) begin
            vec[j][0] = i_data_bits[K-1-j];
            for (int v = 0; v < M; v++) begin
                vec[j][v+1] = i_state[(K-1-j)*M + M-1-v];
            end
        end

        // Recursive feedback, group by group, using groups already updated.
        if (i_cfg.feedback_enable) begin
            for (int i = 0; i < K; i++) begin
                fb_acc = 1'b0;
                for (int j = 0; j < K; j++) begin
                    for (int v = 0; v < G; v++) begin
                        fb_acc = fb_acc ^
                                 (i_cfg.feedback_taps[FW-1-(i*K*G + j*G + v)] & vec[j][v]);
                    end
                end
                vec[i][0] = vec[i][0] ^ fb_acc;
            end
        end

        // Code bits: parity of the output taps over all vectors, first output MSB.
        for (int i = 0; i < ccenc_pkg::N_OUT; i++) begin
            out_acc = 1'b0;
            for (int j = 0; j < K; j++) begin
                for (int v = 0; v < G; v++) begin
                    out_acc = out_acc ^
                              (i_cfg.output_taps[OW-1-(i*K*G + j*G + v)] & vec[j][v]);
                end
            end
            o_code_word[ccenc_pkg::N_OUT-1-i] = out_acc;
        end

        // Shift each group by one; the oldest bit drops out.
        for (int j = 0; j < K; j++) begin
            for (int v = 0; v < M; v++) begin
                o_next_state[(K-1-j)*M + M-1-v] = vec[j][v];
            end
        end
    end

endmodule

FILE: hw/rtl/configurable_convolutional_encoder_unit.sv
// A word accepted into the input register moves on to the output register,
// where its code word shows; the output side can stall it on the way.
// Throughput: one word per cycle while the output does not stall; the encoder state
// updates in the same cycle that a word moves from the input to the output register.
// Reset (synchronous, active low) empties both registers, clears the shift
// state and loads the default taps with feedback disabled.
// ============================================================================
// configurable_convolutional_encoder_unit
// Configurable (n,k,m) convolutional encoder with optional recursive feedback,
// with an input register, combinational encoding logic and an output register.
// ============================================================================
module configurable_convolutional_encoder_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input word channel.
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [ccenc_pkg::K_IN-1:0]      i_data_bits,
    // Output word channel.
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ccenc_pkg::N_OUT-1:0]     o_code_word,
    // Configuration write port.
    input  logic                            i_cfg_we,
    input  logic [ccenc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ccenc_pkg::CFG_W-1:0]     i_cfg_data
);

    ccenc_pkg::t_cfg cfg;

    logic                            r_in_valid;
    logic [ccenc_pkg::K_IN-1:0]      r_in_data;
    logic                            r_out_valid;
    logic [ccenc_pkg::N_OUT-1:0]     r_out_code;
    logic [ccenc_pkg::STATE_W-1:0]   r_state;

    logic [ccenc_pkg::N_OUT-1:0]     n_out_code;
    logic [ccenc_pkg::STATE_W-1:0]   n_state;
    logic                            out_busy;
    logic                            advance;
    logic                            in_accept;

    ccenc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ccenc_core u_core (
        .i_data_bits  (r_in_data),
        .i_state      (r_state),
        .i_cfg        (cfg),
        .o_code_word  (n_out_code),
        .o_next_state (n_state)
    );

    // Handshake: the input register moves on whenever the output register is free.
    assign out_busy  = r_out_valid & i_stall;
    assign advance   = r_in_valid & ~out_busy;
    assign o_stall   = r_in_valid & out_busy;
    assign in_accept = i_valid & ~o_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_data_bits;
        end
    end

    // Output register and encoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (!out_busy) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_code <= n_out_code;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_code_word = r_out_code;

endmodule
